// File: design/lbs_pkg.sv
`timescale 1ns / 1ps
package lbs_pkg;

   localparam int WORDS_PER_BONE = 12;
   localparam int CARRIED_SLOTS  = 4;
   localparam int MAX_INF_DEF    = 4;
   localparam int NUM_BONES_DEF  = 64;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int QCOUNT_W       = 3;
   localparam int BONE_W         = 6;
   localparam int WORD_W         = 4;
   localparam int WEIGHT_W       = 16;
   localparam int MID_W          = 44;
   localparam int REQ_DATA_W     = 232;
   localparam int RSP_DATA_W     = 96;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_SKIN = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic                      wr_ok;
      logic [BONE_W-1:0]         wr_bone;
      logic [WORD_W-1:0]         wr_word;
      logic [31:0]               value;
      logic signed [31:0]        pos_x;
      logic signed [31:0]        pos_y;
      logic signed [31:0]        pos_z;
      logic [2:0]                count;
      logic [4*BONE_W-1:0]       ids;
      logic [4*WEIGHT_W-1:0]     weights;
      logic                      last;
   } item_type;

   typedef struct packed {
      logic                not_empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

// File: design/linear_blend_skinning_unit.sv
`timescale 1ns / 1ps
// A vertex request passes the palette, product, row, weight, sum and output registers.
// One request per cycle unless the output stalls; set by the per-lane palette copies.
// Each palette copy is read once per cycle. Palette load requests yield no result.
// Reset (synchronous, active high) empties the queue and the pipeline; palette
// contents are kept and undefined until written.
module linear_blend_skinning_unit #(
   parameter int MAX_INFLUENCES = lbs_pkg::MAX_INF_DEF,
   parameter int NUM_BONES      = lbs_pkg::NUM_BONES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // palette_index, palette_value, pos_x, pos_y, pos_z, influence_count,
   // bone_ids, bone_weights, zero pad
   input  logic [lbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,   // cmd
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // out_x, out_y, out_z
   output logic                            rsp_tlast
);

   lbs_pkg::item_type          head;
   lbs_pkg::queue_status_type  status;
   logic                       pop;

   lbs_front #(
      .NUM_BONES (NUM_BONES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   lbs_back #(
      .MAX_INFLUENCES (MAX_INFLUENCES),
      .NUM_BONES      (NUM_BONES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (status.not_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= lbs_pkg::QCOUNT_W'(lbs_pkg::QUEUE_DEPTH))
      else $error("request queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.count != '0)
      else $error("pop from empty request queue");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !pop) |=> status.count == $past(status.count) + 1'b1)
      else $error("request queue count lost a push");
`endif

endmodule

// File: design/lbs_front.sv
`timescale 1ns / 1ps
module lbs_front #(
   parameter int NUM_BONES = lbs_pkg::NUM_BONES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lbs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            pop,
   output lbs_pkg::item_type               head,
   output lbs_pkg::queue_status_type       status
);

   localparam int PAL_DEPTH = NUM_BONES * lbs_pkg::WORDS_PER_BONE;

   lbs_pkg::item_type                 queue_ff [lbs_pkg::QUEUE_DEPTH];
   logic [lbs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lbs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lbs_pkg::QCOUNT_W-1:0]      count_ff, count_in;
   logic                              push;
   logic [9:0]                        idx;
   logic [15:0]                       quot;
   logic [lbs_pkg::BONE_W-1:0]        bone;
   logic [9:0]                        word_full;
   lbs_pkg::item_type                 item;

   // word address splits into bone = idx / 12 (as (idx/4) * 171 >> 9) and word = idx % 12
   always_comb begin
      idx       = req_tdata[9:0];
      quot      = 16'(idx[9:2]) * 16'd171;
      bone      = quot[14:9];
      word_full = idx - 10'(bone) * 10'(lbs_pkg::WORDS_PER_BONE);
      item.cmd     = lbs_pkg::cmd_type'(req_tuser);
      item.wr_ok   = 11'(idx) < 11'(PAL_DEPTH);
      item.wr_bone = bone;
      item.wr_word = word_full[lbs_pkg::WORD_W-1:0];
      item.value   = req_tdata[41:10];
      item.pos_x   = req_tdata[73:42];
      item.pos_y   = req_tdata[105:74];
      item.pos_z   = req_tdata[137:106];
      item.count   = req_tdata[140:138];
      item.ids     = req_tdata[164:141];
      item.weights = req_tdata[228:165];
      item.last    = req_tlast;
   end

   assign req_tready = count_ff != lbs_pkg::QCOUNT_W'(lbs_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + lbs_pkg::QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + lbs_pkg::QPTR_W'(pop);
      count_in  = count_ff + lbs_pkg::QCOUNT_W'(push) - lbs_pkg::QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign head             = queue_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.count     = count_ff;

endmodule

// File: design/lbs_back.sv
`timescale 1ns / 1ps
module lbs_back #(
   parameter int MAX_INFLUENCES = lbs_pkg::MAX_INF_DEF,
   parameter int NUM_BONES      = lbs_pkg::NUM_BONES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lbs_pkg::item_type               head,
   input  logic                            head_valid,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int LANES = (MAX_INFLUENCES < lbs_pkg::CARRIED_SLOTS) ?
                          MAX_INFLUENCES : lbs_pkg::CARRIED_SLOTS;
   localparam int AW    = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
   localparam int NW    = lbs_pkg::WORDS_PER_BONE;
   localparam int WT_W  = lbs_pkg::MID_W + lbs_pkg::WEIGHT_W + 1;
   localparam int ACC_W = WT_W + 2;

   function automatic logic signed [lbs_pkg::MID_W-1:0] sat_mid(input logic signed [49:0] v);
      logic signed [lbs_pkg::MID_W-1:0] r;
      if (v[49:lbs_pkg::MID_W-1] == '0 || v[49:lbs_pkg::MID_W-1] == '1) begin
         r = v[lbs_pkg::MID_W-1:0];
      end else begin
         r = v[49] ? {1'b1, {(lbs_pkg::MID_W-1){1'b0}}} : {1'b0, {(lbs_pkg::MID_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_out(input logic signed [ACC_W-16:0] v);
      logic signed [31:0] r;
      if (v[ACC_W-16:31] == '0 || v[ACC_W-16:31] == '1) begin
         r = v[31:0];
      end else begin
         r = v[ACC_W-16] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   logic                               adv;
   logic                               wr_en;
   logic [2:0]                         n_sat;
   logic [LANES-1:0]                   lane_ok;
   logic [AW-1:0]                      rd_addr [LANES];
   logic [lbs_pkg::WEIGHT_W-1:0]       w_in [LANES];

   logic                               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_v_ff;
   logic                               last1_ff, last2_ff, last3_ff, last4_ff, last5_ff, out_last_ff;
   logic signed [31:0]                 mat_ff [LANES][NW];
   logic signed [31:0]                 pos1_ff [3];
   logic [lbs_pkg::WEIGHT_W-1:0]       w1_ff [LANES];
   logic [lbs_pkg::WEIGHT_W-1:0]       w2_ff [LANES];
   logic [lbs_pkg::WEIGHT_W-1:0]       w3_ff [LANES];
   logic signed [63:0]                 prod_ff [LANES][3][3];
   logic signed [31:0]                 m3_ff [LANES][3];
   logic signed [65:0]                 row_sum [LANES][3];
   logic signed [lbs_pkg::MID_W-1:0]   row_ff [LANES][3];
   logic signed [WT_W-1:0]             wt_ff [LANES][3];
   logic signed [ACC_W-1:0]            acc_sum [3];
   logic signed [ACC_W-1:0]            acc_ff [3];
   logic signed [31:0]                 out_ff [3];

   // whole pipeline moves together; the output register frees a slot each accepted result
   assign adv   = !out_v_ff || rsp_tready;
   assign pop   = head_valid && adv;
   assign wr_en = pop && head.cmd == lbs_pkg::CMD_LOAD && head.wr_ok;

   always_comb begin
      n_sat = (head.count > 3'(LANES)) ? 3'(LANES) : head.count;
      for (int l = 0; l < LANES; l++) begin
         lane_ok[l] = (3'(l) < n_sat) &&
                      (7'(head.ids[l*lbs_pkg::BONE_W +: lbs_pkg::BONE_W]) < 7'(NUM_BONES));
         rd_addr[l] = lane_ok[l] ? AW'(head.ids[l*lbs_pkg::BONE_W +: lbs_pkg::BONE_W]) : '0;
         w_in[l]    = lane_ok[l] ? head.weights[l*lbs_pkg::WEIGHT_W +: lbs_pkg::WEIGHT_W] : '0;
      end
   end

   // one palette copy per lane, split by matrix word so a lane reads a whole bone at once
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      for (genvar w = 0; w < NW; w++) begin : g_word
         logic [31:0] palette_ff [NUM_BONES];
         always_ff @(posedge clock) begin
            if (wr_en && head.wr_word == lbs_pkg::WORD_W'(w)) begin
               palette_ff[AW'(head.wr_bone)] <= head.value;
            end
            // unused lanes load zero so they never touch a bone that was not written
            if (adv) begin
               mat_ff[l][w] <= lane_ok[l] ? palette_ff[rd_addr[l]] : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= pop && head.cmd == lbs_pkg::CMD_SKIN;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         out_v_ff <= v5_ff;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int r = 0; r < 3; r++) begin
            row_sum[l][r] = 66'(prod_ff[l][r][0]) + 66'(prod_ff[l][r][1]) +
                            66'(prod_ff[l][r][2]) + (66'(m3_ff[l][r]) <<< 16);
         end
      end
      for (int r = 0; r < 3; r++) begin
         acc_sum[r] = '0;
         for (int l = 0; l < LANES; l++) begin
            acc_sum[r] = acc_sum[r] + ACC_W'(wt_ff[l][r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff[0] <= head.pos_x;
         pos1_ff[1] <= head.pos_y;
         pos1_ff[2] <= head.pos_z;
         last1_ff   <= head.last;
         last2_ff   <= last1_ff;
         last3_ff   <= last2_ff;
         last4_ff   <= last3_ff;
         last5_ff   <= last4_ff;
         out_last_ff <= last5_ff;
         for (int l = 0; l < LANES; l++) begin
            w1_ff[l] <= w_in[l];
            w2_ff[l] <= w1_ff[l];
            w3_ff[l] <= w2_ff[l];
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  prod_ff[l][r][c] <= mat_ff[l][r*4+c] * pos1_ff[c];
               end
               m3_ff[l][r]  <= mat_ff[l][r*4+3];
               row_ff[l][r] <= sat_mid(row_sum[l][r][65:16]);
               wt_ff[l][r]  <= row_ff[l][r] * $signed({1'b0, w3_ff[l]});
            end
         end
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= acc_sum[r];
            out_ff[r] <= sat_out(acc_ff[r][ACC_W-1:15]);
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tlast  = out_last_ff;

endmodule
